/* src/video_line_steering_controller_macros.svh */
// assertion macros shared by the checker
`ifndef VIDEO_LINE_STEERING_CONTROLLER_MACROS_SVH
`define VIDEO_LINE_STEERING_CONTROLLER_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define VLSC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("vlsc assertion failed");

// next-cycle implication, disabled while reset is asserted
`define VLSC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("vlsc assertion failed");

`endif

/* src/vlsc_pkg.sv */
package vlsc_pkg;

    localparam int FRAME_LINES_DEF = 240;
    localparam int ADDR_W          = 5;
    localparam int DATA_W          = 32;

    typedef enum logic [1:0] {
        OP_VSYNC   = 2'd0,
        OP_HSYNC   = 2'd1,
        OP_PORCH   = 2'd2,
        OP_CAPTURE = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        PH_WAIT_VSYNC = 2'd0,
        PH_WAIT_FRAME = 2'd1,
        PH_IN_FRAME   = 2'd2
    } t_phase;

    // register indexes (byte address / 4)
    localparam logic [2:0] REG_ENABLE = 3'd0;
    localparam logic [2:0] REG_KP     = 3'd1;
    localparam logic [2:0] REG_CENTER = 3'd2;
    localparam logic [2:0] REG_TARGET = 3'd3;
    localparam logic [2:0] REG_LOI    = 3'd4;
    localparam logic [2:0] REG_WAIT   = 3'd5;

    localparam logic [15:0] KP_RESET     = 16'd9830;
    localparam logic [7:0]  CENTER_RESET = 8'd74;
    localparam logic [15:0] TARGET_RESET = 16'd65060;
    localparam logic [7:0]  LOI_RESET    = 8'd120;
    localparam logic [3:0]  WAIT_RESET   = 4'd9;

    localparam logic signed [15:0] LAST_DEG_RESET = 16'sd74;

    localparam logic [11:0] SERVO_MIN = 12'd1310;
    localparam logic [11:0] SERVO_MAX = 12'd2620;

    localparam logic signed [15:0] RIGHT_LIMIT = 16'sd150;
    localparam logic [16:0]        JUMP_LIMIT  = 17'd150;

    // saturation bounds of the signed q16.8 angle, held at 27 bits
    localparam logic signed [26:0] Q8_MAX = 27'sd8388607;
    localparam logic signed [26:0] Q8_MIN = -27'sd8388608;

    // a*1310/180 == a*131/18, the divide by 18 done as a reciprocal multiply
    localparam logic [15:0] SCALE_MUL   = 16'd131;
    localparam logic [14:0] RECIP_18    = 15'd29128;
    localparam int          RECIP_SHIFT = 19;

    typedef struct packed {
        logic        enable;
        logic [15:0] kp;
        logic [7:0]  center;
        logic [15:0] target;
        logic [7:0]  loi;
        logic [3:0]  wait_pulses;
    } t_cfg;

    typedef struct packed {
        logic accept;
        logic mul_en;
        logic sum_en;
        logic angle_en;
        logic scale_en;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic capture_go;
    } t_dp_sts;

endpackage

/* src/vlsc_regs.sv */
module vlsc_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [vlsc_pkg::ADDR_W-1:0]    paddr,
    input  logic [vlsc_pkg::DATA_W-1:0]    pwdata,
    output logic [vlsc_pkg::DATA_W-1:0]    prdata,
    output logic                           pready,
    output vlsc_pkg::t_cfg                 o_cfg
);
    import vlsc_pkg::*;

    t_cfg       r_cfg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable      <= 1'b0;
            r_cfg.kp          <= KP_RESET;
            r_cfg.center      <= CENTER_RESET;
            r_cfg.target      <= TARGET_RESET;
            r_cfg.loi         <= LOI_RESET;
            r_cfg.wait_pulses <= WAIT_RESET;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_ENABLE: r_cfg.enable      <= pwdata[0];
                REG_KP:     r_cfg.kp          <= pwdata[15:0];
                REG_CENTER: r_cfg.center      <= pwdata[7:0];
                REG_TARGET: r_cfg.target      <= pwdata[15:0];
                REG_LOI:    r_cfg.loi         <= pwdata[7:0];
                REG_WAIT:   r_cfg.wait_pulses <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_ENABLE: prdata = {31'd0, r_cfg.enable};
            REG_KP:     prdata = {16'd0, r_cfg.kp};
            REG_CENTER: prdata = {24'd0, r_cfg.center};
            REG_TARGET: prdata = {16'd0, r_cfg.target};
            REG_LOI:    prdata = {24'd0, r_cfg.loi};
            REG_WAIT:   prdata = {28'd0, r_cfg.wait_pulses};
            default:    prdata = '0;
        endcase
    end

endmodule

/* src/vlsc_ctrl.sv */
module vlsc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_out_stall,
    input  vlsc_pkg::t_dp_sts i_sts,
    output logic              o_in_stall,
    output logic              o_out_valid,
    output vlsc_pkg::t_dp_cmd o_cmd
);
    import vlsc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_SUM,
        S_ANGLE,
        S_SCALE,
        S_MAP
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;
    logic   accept;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = !((r_state == S_IDLE) && out_free);
    assign accept      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd          = '0;
        o_cmd.accept   = accept;
        o_cmd.mul_en   = (r_state == S_MUL);
        o_cmd.sum_en   = (r_state == S_SUM);
        o_cmd.angle_en = (r_state == S_ANGLE);
        o_cmd.scale_en = (r_state == S_SCALE);
        o_cmd.load_out = (accept && !i_sts.capture_go) || ((r_state == S_MAP) && out_free);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (accept && i_sts.capture_go) n_state = S_MUL;
            S_MUL:   n_state = S_SUM;
            S_SUM:   n_state = S_ANGLE;
            S_ANGLE: n_state = S_SCALE;
            S_SCALE: n_state = S_MAP;
            S_MAP:   if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

/* src/vlsc_dp.sv */
module vlsc_dp #(
    parameter int FRAME_LINES = vlsc_pkg::FRAME_LINES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  vlsc_pkg::t_cfg     i_cfg,
    input  vlsc_pkg::t_dp_cmd  i_cmd,
    output vlsc_pkg::t_dp_sts  o_sts,
    input  logic [1:0]         i_opcode,
    input  logic [15:0]        i_capture_count,
    output logic               o_timer_reset_pulse,
    output logic               o_servo_write,
    output logic [11:0]        o_servo_compare,
    output logic signed [15:0] o_commanded_angle,
    output logic               o_angle_rejected,
    output logic               o_steer_line,
    output logic [1:0]         o_video_phase,
    output logic [7:0]         o_current_line,
    output logic               o_line_seen_flag,
    output logic               o_parity
);
    import vlsc_pkg::*;

    localparam logic [7:0] LINE_LIMIT = 8'(FRAME_LINES);

    t_opcode op;

    // frame tracker
    t_phase             r_phase, n_phase;
    logic [3:0]         r_pulse, n_pulse;
    logic [7:0]         r_line, n_line;
    logic               r_nav, n_nav;
    logic               r_seen, n_seen;
    logic               r_parity, n_parity;
    logic               n_porch;
    logic [3:0]         pulse_inc;
    logic [7:0]         line_inc;
    logic signed [15:0] r_last_deg;

    // steering arithmetic
    logic signed [16:0] r_err;
    logic signed [33:0] r_prod;
    logic signed [33:0] prod_rnd;
    logic signed [25:0] term;
    logic signed [26:0] ang_full;
    logic signed [23:0] r_angle;
    logic signed [23:0] ang_rnd;
    logic signed [15:0] deg_new;
    logic signed [16:0] deg_diff;
    logic [16:0]        deg_abs;
    logic               rej;
    logic signed [15:0] r_cmd_deg;
    logic               r_rej;
    logic               r_lo, r_hi;
    logic [15:0]        r_x;
    logic [30:0]        map_prod;
    logic [11:0]        map_q;
    logic [11:0]        cmp;

    // result register
    logic               r_o_porch, r_o_wr, r_o_rej, r_o_nav, r_o_seen, r_o_parity;
    logic [11:0]        r_o_cmp;
    logic signed [15:0] r_o_angle;
    logic [1:0]         r_o_phase;
    logic [7:0]         r_o_line;

    assign op               = t_opcode'(i_opcode);
    assign o_sts.capture_go = (op == OP_CAPTURE) && i_cfg.enable && (r_line == i_cfg.loi);

    always_comb begin
        n_phase   = r_phase;
        n_pulse   = r_pulse;
        n_line    = r_line;
        n_nav     = r_nav;
        n_seen    = r_seen;
        n_parity  = r_parity;
        n_porch   = 1'b0;
        pulse_inc = r_pulse + 4'd1;
        line_inc  = r_line + 8'd1;
        if (i_cmd.accept) begin
            unique case (op)
                OP_VSYNC: begin
                    n_phase = PH_WAIT_FRAME;
                    n_pulse = 4'd0;
                end
                OP_HSYNC: begin
                    case (r_phase)
                        PH_WAIT_FRAME: begin
                            // a wait count of zero behaves as one
                            if (pulse_inc >= i_cfg.wait_pulses) begin
                                n_pulse = 4'd0;
                                n_phase = PH_IN_FRAME;
                            end else begin
                                n_pulse = pulse_inc;
                            end
                        end
                        PH_IN_FRAME: begin
                            n_nav = (line_inc == i_cfg.loi);
                            if (line_inc >= LINE_LIMIT) begin
                                n_line   = 8'd0;
                                n_seen   = 1'b0;
                                n_phase  = PH_WAIT_VSYNC;
                                n_parity = !r_parity;
                            end else begin
                                n_line = line_inc;
                            end
                        end
                        default: ;
                    endcase
                end
                OP_PORCH:   n_porch = (r_line == i_cfg.loi);
                OP_CAPTURE: ;
                default: ;
            endcase
        end
        if (i_cmd.angle_en) begin
            n_seen = 1'b1;
        end
    end

    // q.8 term truncated toward zero, then center added and saturated
    always_comb begin
        prod_rnd = r_prod + (r_prod[33] ? 34'sd255 : 34'sd0);
        term     = prod_rnd[33:8];
        ang_full = $signed({11'd0, i_cfg.center, 8'd0}) + 27'(term);
        ang_rnd  = r_angle + (r_angle[23] ? 24'sd255 : 24'sd0);
        deg_new  = ang_rnd[23:8];
        deg_diff = 17'(deg_new) - 17'(r_last_deg);
        deg_abs  = deg_diff[16] ? 17'(-deg_diff) : 17'(deg_diff);
        rej      = (deg_abs > JUMP_LIMIT);
        map_prod = 31'(r_x) * 31'(RECIP_18);
        map_q    = map_prod[RECIP_SHIFT+11:RECIP_SHIFT];
        if (r_lo) begin
            cmp = SERVO_MIN;
        end else if (r_hi) begin
            cmp = SERVO_MAX;
        end else begin
            cmp = map_q + SERVO_MIN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_WAIT_VSYNC;
            r_pulse    <= 4'd0;
            r_line     <= 8'd0;
            r_nav      <= 1'b0;
            r_seen     <= 1'b0;
            r_parity   <= 1'b1;
            r_last_deg <= LAST_DEG_RESET;
        end else begin
            r_phase  <= n_phase;
            r_pulse  <= n_pulse;
            r_line   <= n_line;
            r_nav    <= n_nav;
            r_seen   <= n_seen;
            r_parity <= n_parity;
            if (i_cmd.angle_en) begin
                r_last_deg <= rej ? r_last_deg : deg_new;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_err <= $signed({1'b0, i_cfg.target}) - $signed({1'b0, i_capture_count});
        end
        if (i_cmd.mul_en) begin
            r_prod <= 34'($signed({1'b0, i_cfg.kp}) * r_err);
        end
        if (i_cmd.sum_en) begin
            if (ang_full > Q8_MAX) begin
                r_angle <= Q8_MAX[23:0];
            end else if (ang_full < Q8_MIN) begin
                r_angle <= Q8_MIN[23:0];
            end else begin
                r_angle <= ang_full[23:0];
            end
        end
        if (i_cmd.angle_en) begin
            r_cmd_deg <= rej ? r_last_deg : deg_new;
            r_rej     <= rej;
        end
        if (i_cmd.scale_en) begin
            r_lo <= r_cmd_deg[15];
            r_hi <= (r_cmd_deg > RIGHT_LIMIT);
            r_x  <= {8'd0, r_cmd_deg[7:0]} * SCALE_MUL;
        end
        if (i_cmd.load_out) begin
            if (i_cmd.accept) begin
                r_o_porch  <= n_porch;
                r_o_wr     <= 1'b0;
                r_o_cmp    <= 12'd0;
                r_o_angle  <= 16'sd0;
                r_o_rej    <= 1'b0;
                r_o_nav    <= n_nav;
                r_o_phase  <= n_phase;
                r_o_line   <= n_line;
                r_o_seen   <= n_seen;
                r_o_parity <= n_parity;
            end else begin
                r_o_porch  <= 1'b0;
                r_o_wr     <= 1'b1;
                r_o_cmp    <= cmp;
                r_o_angle  <= r_cmd_deg;
                r_o_rej    <= r_rej;
                r_o_nav    <= r_nav;
                r_o_phase  <= r_phase;
                r_o_line   <= r_line;
                r_o_seen   <= r_seen;
                r_o_parity <= r_parity;
            end
        end
    end

    assign o_timer_reset_pulse = r_o_porch;
    assign o_servo_write       = r_o_wr;
    assign o_servo_compare     = r_o_cmp;
    assign o_commanded_angle   = r_o_angle;
    assign o_angle_rejected    = r_o_rej;
    assign o_steer_line        = r_o_nav;
    assign o_video_phase       = r_o_phase;
    assign o_current_line      = r_o_line;
    assign o_line_seen_flag    = r_o_seen;
    assign o_parity            = r_o_parity;

endmodule

/* src/video_line_steering_controller.sv */
// Video line steering controller. Each input transfer is one sync event
// (vsync, hsync, back porch, line capture) and yields exactly one result
// transfer carrying the tracker state after the event. A frame tracker
// (waiting vsync, counting wait_pulses hsyncs, in frame) plus a line counter
// flag the line of interest; a back porch on that line raises
// timer_reset_pulse. A capture on that line with steering enabled computes
// angle = center + kp*(target - count) in signed q16.8, keeps the previous
// angle when the whole-degree jump exceeds 150, and maps the angle to a servo
// compare value of 1310..2620. Timing: for vsync, hsync, back porch and captures
// that do not steer, the result is registered on the accepting edge. A
// steering capture holds off input while the controller walks the datapath
// through multiply, sum and saturate, jump test, scale and servo map; the
// result goes out from the servo map step when the output register is free.
// The output register lets a new event be taken in the cycle the previous
// result leaves. Registers on the APB port, byte addresses: 0x00
// enable_steering, 0x04 kp_gain (unsigned q0.16), 0x08 straight-ahead angle
// in degrees, 0x0c target_count, 0x10 steering line number, 0x14 wait_pulses.
// Write registers only while the block is idle.
module video_line_steering_controller #(
    parameter int FRAME_LINES = vlsc_pkg::FRAME_LINES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // apb configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [vlsc_pkg::ADDR_W-1:0] paddr,
    input  logic [vlsc_pkg::DATA_W-1:0] pwdata,
    output logic [vlsc_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    // event input
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [1:0]                  i_opcode,
    input  logic [15:0]                 i_capture_count,
    // result output
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic                        o_timer_reset_pulse,
    output logic                        o_servo_write,
    output logic [11:0]                 o_servo_compare,
    output logic signed [15:0]          o_commanded_angle,
    output logic                        o_angle_rejected,
    output logic                        o_steer_line,
    output logic [1:0]                  o_video_phase,
    output logic [7:0]                  o_current_line,
    output logic                        o_line_seen_flag,
    output logic                        o_parity
);
    import vlsc_pkg::*;

    t_cfg    cfg;
    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    // configuration registers
    vlsc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // sequencer: accepts transfers and steps the steering stages
    vlsc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (dp_sts),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (dp_cmd)
    );

    // frame tracker, steering arithmetic and result register
    vlsc_dp #(
        .FRAME_LINES (FRAME_LINES)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg               (cfg),
        .i_cmd               (dp_cmd),
        .o_sts               (dp_sts),
        .i_opcode            (i_opcode),
        .i_capture_count     (i_capture_count),
        .o_timer_reset_pulse (o_timer_reset_pulse),
        .o_servo_write       (o_servo_write),
        .o_servo_compare     (o_servo_compare),
        .o_commanded_angle   (o_commanded_angle),
        .o_angle_rejected    (o_angle_rejected),
        .o_steer_line        (o_steer_line),
        .o_video_phase       (o_video_phase),
        .o_current_line      (o_current_line),
        .o_line_seen_flag    (o_line_seen_flag),
        .o_parity            (o_parity)
    );

endmodule

/* src/vlsc_checker.sv */
`include "video_line_steering_controller_macros.svh"

module vlsc_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic               o_timer_reset_pulse,
    input logic               o_servo_write,
    input logic [11:0]        o_servo_compare,
    input logic signed [15:0] o_commanded_angle,
    input logic               o_angle_rejected,
    input logic               o_line_seen_flag
);
    import vlsc_pkg::*;

    // servo compare stays inside the pwm window when written
    `VLSC_ASSERT_NOW(a_cmp_range, o_out_valid && o_servo_write, (o_servo_compare >= SERVO_MIN) && (o_servo_compare <= SERVO_MAX))

    // no servo write means all servo fields idle
    `VLSC_ASSERT_NOW(a_idle_fields, o_out_valid && !o_servo_write, (o_servo_compare == 12'd0) && (o_commanded_angle == 16'sd0) && !o_angle_rejected)

    // a steering capture marks the line as seen
    `VLSC_ASSERT_NOW(a_seen_on_write, o_out_valid && o_servo_write, o_line_seen_flag)

    // porch pulse and servo write come from different events
    `VLSC_ASSERT_NOW(a_porch_excl, o_out_valid, !(o_timer_reset_pulse && o_servo_write))

    // stalled result holds
    `VLSC_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_servo_compare) && $stable(o_commanded_angle))

endmodule

bind video_line_steering_controller vlsc_checker u_checker (.*);

/* tb/sv/tb_video_line_steering_controller.sv */
module tb_video_line_steering_controller;
    timeunit 1ns;
    timeprecision 1ps;

    import vlsc_pkg::*;

    localparam int FRAME_LINES      = FRAME_LINES_DEF;
    localparam int DRAIN_CYCLES     = 8;       // margin for a steering capture to finish
    localparam int IDLE_PCT         = 21;      // chance per cycle that a side idles
    localparam int HOLD_CYCLES      = 80;      // long receiver hold-off, fills the block
    localparam int NUM_PHASES       = 10;
    localparam int PHASE_ITEMS      = 50;
    localparam int LAST_PHASE_ITEMS = 320;     // long enough to climb to line 240
    localparam int TIMEOUT_NS       = 5_000_000;

    // angle and servo arithmetic, in whole numbers
    localparam longint Q8_TOP    = 8388607;
    localparam longint Q8_BOTTOM = -8388608;
    localparam longint SERVO_LO  = 1310;
    localparam longint SERVO_HI  = 2620;
    localparam longint SPAN_DEG  = 180;
    localparam longint RIGHT_DEG = 150;
    localparam longint JUMP_DEG  = 150;

    // one result transfer, field for field
    typedef struct packed {
        logic               porch;
        logic               wr;
        logic [11:0]        cmp;
        logic signed [15:0] cmd;
        logic               rej;
        logic               nav;
        t_phase             ph;
        logic [7:0]         line;
        logic               seen;
        logic               par;
    } t_steer_result;

    typedef struct packed {
        logic        enable;
        logic [15:0] kp;
        logic [7:0]  center;
        logic [15:0] target;
        logic [7:0]  loi;
        logic [3:0]  wait_pulses;
    } t_steer_regs;

    typedef enum { ROW_CFG, ROW_EVENT, ROW_CHECKED } t_row_kind;

    typedef struct {
        t_row_kind     kind;
        logic [2:0]    reg_idx;
        logic [31:0]   value;
        t_opcode       op;
        logic [15:0]   cnt;
        t_steer_result want;
    } t_dir_row;

    // clock, reset and every block input start at known values
    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [ADDR_W-1:0]  paddr = '0;
    logic [DATA_W-1:0]  pwdata = '0;
    logic [DATA_W-1:0]  prdata;
    logic               pready;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic [1:0]         i_opcode = '0;
    logic [15:0]        i_capture_count = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic               o_timer_reset_pulse;
    logic               o_servo_write;
    logic [11:0]        o_servo_compare;
    logic signed [15:0] o_commanded_angle;
    logic               o_angle_rejected;
    logic               o_steer_line;
    logic [1:0]         o_video_phase;
    logic [7:0]         o_current_line;
    logic               o_line_seen_flag;
    logic               o_parity;

    // register copy and tracker state, at their reset values
    t_steer_regs regs = '{1'b0, KP_RESET, CENTER_RESET, TARGET_RESET, LOI_RESET, WAIT_RESET};
    t_phase      trk_phase  = PH_WAIT_VSYNC;
    logic [3:0]  trk_pulses = '0;
    logic [7:0]  trk_line   = '0;
    logic        trk_nav    = 1'b0;
    logic        trk_seen   = 1'b0;
    logic        trk_parity = 1'b1;
    longint      held_angle = 74 * 256;     // last commanded angle in q.8

    t_steer_result pending_results[$];      // expected results, oldest first
    t_dir_row      dir_rows[$];
    int            mismatches  = 0;
    bit            calm        = 1'b0;      // no idling on either side while set
    int            hold_asks   = 0;
    int            hold_served = 0;
    int            hold_left   = 0;

    video_line_steering_controller #(
        .FRAME_LINES(FRAME_LINES)
    ) DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_opcode           (i_opcode),
        .i_capture_count    (i_capture_count),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_timer_reset_pulse(o_timer_reset_pulse),
        .o_servo_write      (o_servo_write),
        .o_servo_compare    (o_servo_compare),
        .o_commanded_angle  (o_commanded_angle),
        .o_angle_rejected   (o_angle_rejected),
        .o_steer_line       (o_steer_line),
        .o_video_phase      (o_video_phase),
        .o_current_line     (o_current_line),
        .o_line_seen_flag   (o_line_seen_flag),
        .o_parity           (o_parity)
    );

    always #10 i_clk = ~i_clk;

    // advance the tracker by one sync event and return the result it yields
    function automatic t_steer_result steer_event(t_opcode op, logic [15:0] cnt);
        t_steer_result r;
        longint        err;
        longint        ang;
        longint        jump;
        longint        deg;
        r = '0;
        case (op)
            OP_VSYNC: begin
                // line counter is kept across vsync
                trk_phase  = PH_WAIT_FRAME;
                trk_pulses = '0;
            end
            OP_HSYNC: begin
                if (trk_phase == PH_WAIT_FRAME) begin
                    // a wait count of zero behaves like one
                    trk_pulses = trk_pulses + 4'd1;
                    if (trk_pulses >= regs.wait_pulses) begin
                        trk_pulses = '0;
                        trk_phase  = PH_IN_FRAME;
                    end
                end else if (trk_phase == PH_IN_FRAME) begin
                    trk_line = trk_line + 8'd1;
                    trk_nav  = (trk_line == regs.loi);
                    // frame end: nav keeps the value it just took
                    if (trk_line >= FRAME_LINES) begin
                        trk_line   = '0;
                        trk_seen   = 1'b0;
                        trk_phase  = PH_WAIT_VSYNC;
                        trk_parity = ~trk_parity;
                    end
                end
            end
            OP_PORCH: begin
                // phase is not looked at
                r.porch = (trk_line == regs.loi);
            end
            default: begin
                if (regs.enable && trk_line == regs.loi) begin
                    err = longint'(regs.target) - longint'(cnt);
                    ang = longint'(regs.center) * 256 + (longint'(regs.kp) * err) / 256;
                    if (ang > Q8_TOP)
                        ang = Q8_TOP;
                    if (ang < Q8_BOTTOM)
                        ang = Q8_BOTTOM;
                    // jump test on whole degrees, truncated toward zero
                    jump = ang / 256 - held_angle / 256;
                    if (jump < 0)
                        jump = -jump;
                    if (jump > JUMP_DEG) begin
                        ang   = held_angle;
                        r.rej = 1'b1;
                    end
                    held_angle = ang;
                    trk_seen   = 1'b1;
                    deg        = ang / 256;
                    r.wr       = 1'b1;
                    r.cmd      = 16'(deg);
                    if (deg < 0)
                        r.cmp = 12'(SERVO_LO);
                    else if (deg > RIGHT_DEG)
                        r.cmp = 12'(SERVO_HI);
                    else
                        r.cmp = 12'(deg * (SERVO_HI - SERVO_LO) / SPAN_DEG + SERVO_LO);
                end
            end
        endcase
        r.nav  = trk_nav;
        r.ph   = trk_phase;
        r.line = trk_line;
        r.seen = trk_seen;
        r.par  = trk_parity;
        return r;
    endfunction

    task automatic add_cfg(logic [2:0] idx, logic [31:0] val);
        t_dir_row r;
        r.kind    = ROW_CFG;
        r.reg_idx = idx;
        r.value   = val;
        r.op      = OP_VSYNC;
        r.cnt     = '0;
        r.want    = '0;
        dir_rows.push_back(r);
    endtask

    task automatic add_ev(t_row_kind kind, t_opcode op, logic [15:0] cnt,
                          t_steer_result want = '0);
        t_dir_row r;
        r.kind    = kind;
        r.reg_idx = '0;
        r.value   = '0;
        r.op      = op;
        r.cnt     = cnt;
        r.want    = want;
        dir_rows.push_back(r);
    endtask

    // register write through the apb port, only once every result is back
    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        // setup cycle
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        // access cycle, the register takes the value at the next edge
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_ENABLE: regs.enable      = val[0];
            REG_KP:     regs.kp          = val[15:0];
            REG_CENTER: regs.center      = val[7:0];
            REG_TARGET: regs.target      = val[15:0];
            REG_LOI:    regs.loi         = val[7:0];
            REG_WAIT:   regs.wait_pulses = val[3:0];
            default: ;
        endcase
    endtask

    // offer one event, hold it until the transfer, then predict its result
    task automatic send_event(t_opcode op, logic [15:0] cnt, bit typed,
                              t_steer_result typed_want);
        t_steer_result predicted;
        // idle cycles drawn one at a time
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_opcode        <= op;
        i_capture_count <= cnt;
        do
            @(posedge i_clk);
        while (o_in_stall);
        predicted = steer_event(op, cnt);
        // the tracker always advances; a typed row replaces the prediction
        pending_results.push_back(typed ? typed_want : predicted);
    endtask

    task automatic check_field(string name, logic signed [31:0] want,
                               logic signed [31:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
        end
    endtask

    // receiver: random stall, a quiet stretch, and one long hold-off on request
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left   <= hold_left - 1;
        end else if (hold_asks != hold_served) begin
            hold_served <= hold_asks;
            hold_left   <= HOLD_CYCLES - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    // result checker, compares each transfer with the oldest expectation
    always @(posedge i_clk) begin
        t_steer_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                $display("%0t: result transfer expected none actual one", $time);
            end else begin
                want = pending_results.pop_front();
                check_field("timer_reset_pulse", want.porch, o_timer_reset_pulse);
                check_field("servo_write", want.wr, o_servo_write);
                check_field("servo_compare", want.cmp, o_servo_compare);
                check_field("commanded_angle", want.cmd, o_commanded_angle);
                check_field("angle_rejected", want.rej, o_angle_rejected);
                check_field("steer_line", want.nav, o_steer_line);
                check_field("video_phase", want.ph, o_video_phase);
                check_field("current_line", want.line, o_current_line);
                check_field("line_seen_flag", want.seen, o_line_seen_flag);
                check_field("parity", want.par, o_parity);
            end
        end
    end

    initial begin
        #(TIMEOUT_NS);
        $display("FAIL video_line_steering_controller");
        $finish;
    end

    initial begin
        t_opcode     op;
        logic [15:0] cnt;
        logic [7:0]  near;
        int          roll;
        int          items;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // defaults after reset: hsync before vsync, porch and capture off the line
        add_ev(ROW_CHECKED, OP_HSYNC, 16'h0000,
               '{1'b0, 1'b0, 12'd0, 16'sd0, 1'b0, 1'b0, PH_WAIT_VSYNC, 8'd0, 1'b0, 1'b1});
        add_ev(ROW_CHECKED, OP_PORCH, 16'hFFFF,
               '{1'b0, 1'b0, 12'd0, 16'sd0, 1'b0, 1'b0, PH_WAIT_VSYNC, 8'd0, 1'b0, 1'b1});
        // steering off, capture does nothing
        add_ev(ROW_CHECKED, OP_CAPTURE, 16'h0000,
               '{1'b0, 1'b0, 12'd0, 16'sd0, 1'b0, 1'b0, PH_WAIT_VSYNC, 8'd0, 1'b0, 1'b1});
        add_ev(ROW_CHECKED, OP_VSYNC, 16'h0000,
               '{1'b0, 1'b0, 12'd0, 16'sd0, 1'b0, 1'b0, PH_WAIT_FRAME, 8'd0, 1'b0, 1'b1});
        add_ev(ROW_EVENT, OP_HSYNC, 16'hFFFF);
        // line zero of interest, so captures steer at once
        add_cfg(REG_ENABLE, 32'd1);
        add_cfg(REG_LOI, 32'd0);
        // back porch on the line, outside the frame
        add_ev(ROW_CHECKED, OP_PORCH, 16'h1234,
               '{1'b1, 1'b0, 12'd0, 16'sd0, 1'b0, 1'b0, PH_WAIT_FRAME, 8'd0, 1'b0, 1'b1});
        // centered line keeps the default angle
        add_ev(ROW_CHECKED, OP_CAPTURE, TARGET_RESET,
               '{1'b0, 1'b1, 12'd1848, 16'sd74, 1'b0, 1'b0, PH_WAIT_FRAME, 8'd0, 1'b1, 1'b1});
        // huge error, jump rejected, previous angle reused
        add_ev(ROW_CHECKED, OP_CAPTURE, 16'h0000,
               '{1'b0, 1'b1, 12'd1848, 16'sd74, 1'b1, 1'b0, PH_WAIT_FRAME, 8'd0, 1'b1, 1'b1});
        // zero gain: angle equals center, walk the servo map edges
        add_cfg(REG_KP, 32'd0);
        add_cfg(REG_CENTER, 32'd180);
        add_ev(ROW_CHECKED, OP_CAPTURE, 16'h5A5A,
               '{1'b0, 1'b1, 12'd2620, 16'sd180, 1'b0, 1'b0, PH_WAIT_FRAME, 8'd0, 1'b1, 1'b1});
        add_cfg(REG_CENTER, 32'd150);
        add_ev(ROW_CHECKED, OP_CAPTURE, 16'h0000,
               '{1'b0, 1'b1, 12'd2401, 16'sd150, 1'b0, 1'b0, PH_WAIT_FRAME, 8'd0, 1'b1, 1'b1});
        // jump of exactly 150 still passes
        add_cfg(REG_CENTER, 32'd0);
        add_ev(ROW_CHECKED, OP_CAPTURE, 16'hFFFF,
               '{1'b0, 1'b1, 12'd1310, 16'sd0, 1'b0, 1'b0, PH_WAIT_FRAME, 8'd0, 1'b1, 1'b1});
        // jump of 151 is rejected
        add_cfg(REG_CENTER, 32'd151);
        add_ev(ROW_CHECKED, OP_CAPTURE, 16'h1234,
               '{1'b0, 1'b1, 12'd1310, 16'sd0, 1'b1, 1'b0, PH_WAIT_FRAME, 8'd0, 1'b1, 1'b1});
        // full gain: negative angle, then saturation both ways
        add_cfg(REG_KP, 32'hFFFF);
        add_cfg(REG_CENTER, 32'd0);
        add_cfg(REG_TARGET, 32'd0);
        add_ev(ROW_EVENT, OP_CAPTURE, 16'd100);
        add_cfg(REG_TARGET, 32'hFFFF);
        add_cfg(REG_CENTER, 32'd180);
        add_ev(ROW_EVENT, OP_CAPTURE, 16'h0000);
        add_cfg(REG_TARGET, 32'd0);
        add_cfg(REG_CENTER, 32'd0);
        add_ev(ROW_EVENT, OP_CAPTURE, 16'hFFFF);
        // wait count of zero, frame starts on the next hsync
        add_cfg(REG_WAIT, 32'd0);
        add_ev(ROW_EVENT, OP_HSYNC, 16'h0000);
        add_ev(ROW_EVENT, OP_HSYNC, 16'h0000);
        add_cfg(REG_LOI, 32'd1);
        add_ev(ROW_EVENT, OP_PORCH, 16'h0000);
        add_ev(ROW_EVENT, OP_CAPTURE, 16'hFFFF);
        add_ev(ROW_EVENT, OP_VSYNC, 16'hFFFF);
        add_ev(ROW_EVENT, OP_HSYNC, 16'h0000);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_CFG)
                write_reg(dir_rows[i].reg_idx, dir_rows[i].value);
            else
                send_event(dir_rows[i].op, dir_rows[i].cnt,
                           dir_rows[i].kind == ROW_CHECKED, dir_rows[i].want);
        end

        // random part, one register setting per phase
        for (int p = 0; p < NUM_PHASES; p++) begin
            // line of interest a short walk ahead of the current line
            near = trk_line + 8'($urandom_range(1, 20));
            if (near > FRAME_LINES)
                near = 8'($urandom_range(0, 20));
            write_reg(REG_ENABLE, (p != 4) ? 32'd1 : 32'd0);
            write_reg(REG_KP, (p == 1) ? 32'hFFFF : (p == 3) ? 32'd0 : $urandom_range(0, 8192));
            write_reg(REG_CENTER, (p == 1) ? 32'd180 : (p == 3) ? 32'd0 : $urandom_range(0, 180));
            write_reg(REG_TARGET, (p == 1) ? 32'hFFFF : (p == 5) ? 32'd0
                                           : $urandom_range(0, 65535));
            // line 255 is never reached; line 240 flags nav right at frame end
            write_reg(REG_LOI, (p == 4) ? 32'd255 : (p == NUM_PHASES - 1) ? 32'd240
                                        : 32'(near));
            write_reg(REG_WAIT, (p == 0) ? 32'd15 : (p == 2) ? 32'd0 : (p == 6) ? 32'd1
                                         : $urandom_range(1, 15));
            calm = (p == 3);
            if (p == 1)
                hold_asks++;
            items = (p == NUM_PHASES - 1) ? LAST_PHASE_ITEMS : PHASE_ITEMS;
            repeat (items) begin
                roll = $urandom_range(0, 99);
                cnt  = 16'($urandom_range(0, 65535));
                if (roll < 8) begin
                    // noise, any event anywhere
                    op = t_opcode'($urandom_range(0, 3));
                end else if (trk_phase == PH_WAIT_VSYNC) begin
                    op = (roll < 70) ? OP_VSYNC : OP_HSYNC;
                end else if (trk_phase == PH_WAIT_FRAME) begin
                    op = (roll < 92) ? OP_HSYNC : OP_PORCH;
                end else if (trk_line == regs.loi) begin
                    // dwell on the line of interest: captures and porches
                    op = (roll < 55) ? OP_CAPTURE : (roll < 80) ? OP_PORCH
                       : (roll < 88) ? OP_VSYNC : OP_HSYNC;
                    if (roll < 40)
                        cnt = regs.target + 16'($urandom_range(0, 2048) - 1024);
                    else if (roll < 48)
                        cnt = roll[0] ? 16'hFFFF : 16'h0000;
                end else begin
                    op = (roll < 90) ? OP_HSYNC : (roll < 94) ? OP_PORCH
                       : (roll < 97) ? OP_CAPTURE : OP_VSYNC;
                end
                send_event(op, cnt, 1'b0, '0);
            end
        end
        calm = 1'b0;

        // drain, then give the block time to show any extra result
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("PASS video_line_steering_controller");
        else
            $display("FAIL video_line_steering_controller");
        $finish;
    end

endmodule
